// File: hw/rtl/vmac_pkg.sv
// ----------------------------------------------------------------------------
// vmac_pkg: shared types and codes of the video memory access block
// Command codes, the decoded operation that travels from the front end to the
// back end, result kinds and the back-end sequencer states.
// ----------------------------------------------------------------------------
package vmac_pkg;

    localparam int CMD_BITS   = 4;
    localparam int FIELD_BITS = 16;
    // color and scroll memories hold at least 16 entries, so addr / entries < 2^12
    localparam int QUOT_BITS  = 12;

    localparam logic [CMD_BITS-1:0] CMD_RD_BYTE   = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_RD_WORD   = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_WR_BYTE   = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_WR_WORD   = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_RD_COLOR  = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_WR_COLOR  = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_RD_SCROLL = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_WR_SCROLL = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_FILL      = 4'd8;
    localparam logic [CMD_BITS-1:0] CMD_COPY      = 4'd9;

    typedef enum logic [3:0] {
        K_NOP,
        K_RD_BYTE,
        K_RD_WORD,
        K_WR_BYTE,
        K_WR_WORD,
        K_RD_COLOR,
        K_WR_COLOR,
        K_RD_SCROLL,
        K_WR_SCROLL,
        K_FILL,
        K_COPY
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [FIELD_BITS-1:0]  addr;
        logic [FIELD_BITS-1:0]  data;
        logic [FIELD_BITS-1:0]  src;
        logic [FIELD_BITS-1:0]  len;
        logic [QUOT_BITS-1:0]   quot;
    } t_op;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_BYTE,
        RES_WORD,
        RES_COLOR,
        RES_SCROLL
    } t_res;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FILL,
        ST_COPY
    } t_state;

endpackage

// File: hw/rtl/vmac_queue.sv
// ----------------------------------------------------------------------------
// vmac_queue: small synchronous FIFO
// Register-based queue with full and empty flags; the head entry is shown
// while empty is low.
// ----------------------------------------------------------------------------
module vmac_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [AW:0]      r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (w_rd) begin
                r_rptr <= r_rptr + AW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/vmac_front.sv
// ----------------------------------------------------------------------------
// vmac_front: request decoder
// Classifies each request into an operation kind and works out the quotient
// of the address by the color or scroll memory size with a reciprocal
// multiply, so the back end only has to form the remainder.
// ----------------------------------------------------------------------------
module vmac_front #(
    parameter int COLOR_ENTRIES  = 64,
    parameter int SCROLL_ENTRIES = 64
) (
    input  logic [vmac_pkg::CMD_BITS-1:0]   i_cmd,
    input  logic [vmac_pkg::FIELD_BITS-1:0] i_addr,
    input  logic [vmac_pkg::FIELD_BITS-1:0] i_data,
    input  logic [vmac_pkg::FIELD_BITS-1:0] i_source_addr,
    input  logic [vmac_pkg::FIELD_BITS-1:0] i_length,
    output vmac_pkg::t_op                   o_op
);

    import vmac_pkg::*;

    localparam int PROD_BITS = 2*FIELD_BITS + 1;
    localparam int C_SHIFT   = FIELD_BITS + $clog2(COLOR_ENTRIES);
    localparam int S_SHIFT   = FIELD_BITS + $clog2(SCROLL_ENTRIES);
    // ceil(2^shift / entries) gives the exact quotient for every 16-bit address
    localparam logic [FIELD_BITS:0] C_RECIP =
        (FIELD_BITS+1)'(((1 << C_SHIFT) + COLOR_ENTRIES - 1) / COLOR_ENTRIES);
    localparam logic [FIELD_BITS:0] S_RECIP =
        (FIELD_BITS+1)'(((1 << S_SHIFT) + SCROLL_ENTRIES - 1) / SCROLL_ENTRIES);

    logic [PROD_BITS-1:0] w_cprod;
    logic [PROD_BITS-1:0] w_sprod;
    logic [QUOT_BITS-1:0] w_cquot;
    logic [QUOT_BITS-1:0] w_squot;
    logic                 w_zero_len;

    assign w_cprod    = PROD_BITS'(i_addr) * PROD_BITS'(C_RECIP);
    assign w_sprod    = PROD_BITS'(i_addr) * PROD_BITS'(S_RECIP);
    assign w_cquot    = QUOT_BITS'(w_cprod >> C_SHIFT);
    assign w_squot    = QUOT_BITS'(w_sprod >> S_SHIFT);
    assign w_zero_len = (i_length == '0);

    always_comb begin
        o_op.addr = i_addr;
        o_op.data = i_data;
        o_op.src  = i_source_addr;
        o_op.len  = i_length;
        o_op.quot = w_cquot;
        case (i_cmd)
            CMD_RD_BYTE:   o_op.kind = K_RD_BYTE;
            CMD_RD_WORD:   o_op.kind = K_RD_WORD;
            CMD_WR_BYTE:   o_op.kind = K_WR_BYTE;
            CMD_WR_WORD:   o_op.kind = K_WR_WORD;
            CMD_RD_COLOR:  o_op.kind = K_RD_COLOR;
            CMD_WR_COLOR:  o_op.kind = K_WR_COLOR;
            CMD_RD_SCROLL: begin
                o_op.kind = K_RD_SCROLL;
                o_op.quot = w_squot;
            end
            CMD_WR_SCROLL: begin
                o_op.kind = K_WR_SCROLL;
                o_op.quot = w_squot;
            end
            // a transfer of no bytes only answers
            CMD_FILL:      o_op.kind = w_zero_len ? K_NOP : K_FILL;
            CMD_COPY:      o_op.kind = w_zero_len ? K_NOP : K_COPY;
            default:       o_op.kind = K_NOP;
        endcase
    end

endmodule

// File: hw/rtl/vmac_back.sv
// ----------------------------------------------------------------------------
// vmac_back: memory execution unit
// Holds the video memory as even and odd byte banks, the color and scroll
// memories, and sequences single accesses, fills and copies, one byte per
// cycle for transfers. A result stage holds read data until it is queued.
// ----------------------------------------------------------------------------
module vmac_back #(
    parameter int VIDEO_ADDR_BITS = 16,
    parameter int COLOR_ENTRIES   = 64,
    parameter int SCROLL_ENTRIES  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_op_valid,
    input  vmac_pkg::t_op                   i_op,
    output logic                            o_pop,
    input  logic                            i_res_full,
    output logic                            o_res_push,
    output logic [vmac_pkg::FIELD_BITS-1:0] o_res_data
);

    import vmac_pkg::*;

    localparam int VAB  = VIDEO_ADDR_BITS;
    localparam int RB   = VAB - 1;
    localparam int ROWS = 1 << RB;
    localparam int CIB  = $clog2(COLOR_ENTRIES);
    localparam int SIB  = $clog2(SCROLL_ENTRIES);
    localparam int CW   = 12;
    localparam int SW   = 10;

    // storage
    logic [7:0]  r_vm_even [ROWS];
    logic [7:0]  r_vm_odd  [ROWS];
    logic [CW-1:0] r_color_mem [COLOR_ENTRIES];
    logic [SW-1:0] r_scroll_mem [SCROLL_ENTRIES];
    logic [COLOR_ENTRIES-1:0]  r_cval;
    logic [SCROLL_ENTRIES-1:0] r_sval;
    logic [7:0]    r_ev_rd;
    logic [7:0]    r_od_rd;
    logic [CW-1:0] r_c_rd;
    logic [SW-1:0] r_s_rd;

    // memory ports
    logic          w_ev_we, w_ev_re, w_od_we, w_od_re;
    logic [RB-1:0] w_ev_wa, w_ev_ra, w_od_wa, w_od_ra;
    logic [7:0]    w_ev_wd, w_od_wd;
    logic          w_c_we, w_c_re, w_s_we, w_s_re;
    logic [CIB-1:0] w_c_idx;
    logic [SIB-1:0] w_s_idx;

    // sequencer
    t_state        r_state, n_state;
    logic [VAB-1:0] r_ptr_src, n_ptr_src;
    logic [VAB-1:0] r_ptr_dst, n_ptr_dst;
    logic [VAB-1:0] r_cw_dst, n_cw_dst;
    logic [FIELD_BITS-1:0] r_cnt, n_cnt;
    logic          r_back, n_back;
    logic [7:0]    r_fill, n_fill;
    logic          r_cw_valid, n_cw_valid;
    logic          r_cw_bank, n_cw_bank;
    logic          r_res_valid, n_res_valid;
    t_res          r_res_kind, n_res_kind;
    logic          r_res_bank, n_res_bank;

    // decoded request
    logic [VAB-1:0] w_va;
    logic [VAB-1:0] w_src;
    logic [VAB-1:0] w_len1;
    logic           w_dir_back;
    logic           w_res_free;
    logic [7:0]     w_cp_byte;
    logic [FIELD_BITS-1:0] w_cmul;
    logic [FIELD_BITS-1:0] w_smul;

    assign w_va       = VAB'(i_op.addr);
    assign w_src      = VAB'(i_op.src);
    assign w_len1     = VAB'(i_op.len - FIELD_BITS'(1));
    assign w_dir_back = (w_va > w_src);
    assign w_cmul     = FIELD_BITS'(FIELD_BITS'(i_op.quot) * FIELD_BITS'(COLOR_ENTRIES));
    assign w_smul     = FIELD_BITS'(FIELD_BITS'(i_op.quot) * FIELD_BITS'(SCROLL_ENTRIES));
    assign w_c_idx    = CIB'(i_op.addr - w_cmul);
    assign w_s_idx    = SIB'(i_op.addr - w_smul);
    assign w_res_free = !r_res_valid || !i_res_full;
    assign o_res_push = r_res_valid && !i_res_full;
    assign w_cp_byte  = r_cw_bank ? r_od_rd : r_ev_rd;

    // video banks, write-first so a copy sees the byte it has just written
    always_ff @(posedge i_clk) begin
        if (w_ev_we) begin
            r_vm_even[w_ev_wa] <= w_ev_wd;
        end
        if (w_ev_re) begin
            r_ev_rd <= (w_ev_we && w_ev_wa == w_ev_ra) ? w_ev_wd : r_vm_even[w_ev_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_od_we) begin
            r_vm_odd[w_od_wa] <= w_od_wd;
        end
        if (w_od_re) begin
            r_od_rd <= (w_od_we && w_od_wa == w_od_ra) ? w_od_wd : r_vm_odd[w_od_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_we) begin
            r_color_mem[w_c_idx] <= i_op.data[CW-1:0];
        end
        if (w_c_re) begin
            r_c_rd <= r_cval[w_c_idx] ? r_color_mem[w_c_idx] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            r_scroll_mem[w_s_idx] <= i_op.data[SW-1:0];
        end
        if (w_s_re) begin
            r_s_rd <= r_sval[w_s_idx] ? r_scroll_mem[w_s_idx] : '0;
        end
    end

    // entries read as zero until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cval <= '0;
            r_sval <= '0;
        end else begin
            if (w_c_we) begin
                r_cval[w_c_idx] <= 1'b1;
            end
            if (w_s_we) begin
                r_sval[w_s_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cnt       <= '0;
            r_cw_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_res_kind  <= RES_ZERO;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cw_valid  <= n_cw_valid;
            r_res_valid <= n_res_valid;
            r_res_kind  <= n_res_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr_src  <= n_ptr_src;
        r_ptr_dst  <= n_ptr_dst;
        r_cw_dst   <= n_cw_dst;
        r_back     <= n_back;
        r_fill     <= n_fill;
        r_cw_bank  <= n_cw_bank;
        r_res_bank <= n_res_bank;
    end

    always_comb begin
        n_state     = r_state;
        n_ptr_src   = r_ptr_src;
        n_ptr_dst   = r_ptr_dst;
        n_cw_dst    = r_cw_dst;
        n_cnt       = r_cnt;
        n_back      = r_back;
        n_fill      = r_fill;
        n_cw_valid  = r_cw_valid;
        n_cw_bank   = r_cw_bank;
        n_res_valid = r_res_valid && i_res_full;
        n_res_kind  = r_res_kind;
        n_res_bank  = r_res_bank;
        o_pop       = 1'b0;
        w_ev_we     = 1'b0;
        w_ev_re     = 1'b0;
        w_od_we     = 1'b0;
        w_od_re     = 1'b0;
        w_ev_wa     = w_va[VAB-1:1];
        w_od_wa     = w_va[VAB-1:1];
        w_ev_ra     = w_va[VAB-1:1];
        w_od_ra     = w_va[VAB-1:1];
        w_ev_wd     = i_op.data[7:0];
        w_od_wd     = i_op.data[7:0];
        w_c_we      = 1'b0;
        w_c_re      = 1'b0;
        w_s_we      = 1'b0;
        w_s_re      = 1'b0;

        case (r_state)
            ST_RUN: begin
                if (i_op_valid && w_res_free) begin
                    o_pop       = 1'b1;
                    n_res_valid = 1'b1;
                    n_res_kind  = RES_ZERO;
                    case (i_op.kind)
                        K_RD_BYTE: begin
                            w_ev_re    = !w_va[0];
                            w_od_re    = w_va[0];
                            n_res_kind = RES_BYTE;
                            n_res_bank = w_va[0];
                        end
                        K_RD_WORD: begin
                            w_ev_re    = 1'b1;
                            w_od_re    = 1'b1;
                            n_res_kind = RES_WORD;
                        end
                        K_WR_BYTE: begin
                            w_ev_we = !w_va[0];
                            w_od_we = w_va[0];
                        end
                        K_WR_WORD: begin
                            // high byte sits at the even address
                            w_ev_we = 1'b1;
                            w_od_we = 1'b1;
                            w_ev_wd = i_op.data[15:8];
                        end
                        K_RD_COLOR: begin
                            w_c_re     = 1'b1;
                            n_res_kind = RES_COLOR;
                        end
                        K_WR_COLOR: begin
                            w_c_we = 1'b1;
                        end
                        K_RD_SCROLL: begin
                            w_s_re     = 1'b1;
                            n_res_kind = RES_SCROLL;
                        end
                        K_WR_SCROLL: begin
                            w_s_we = 1'b1;
                        end
                        K_FILL: begin
                            n_res_valid = 1'b0;
                            n_state     = ST_FILL;
                            n_ptr_dst   = w_va;
                            n_cnt       = i_op.len;
                            n_fill      = i_op.data[7:0];
                        end
                        K_COPY: begin
                            // overlap-safe: run downward when the destination is higher
                            n_res_valid = 1'b0;
                            n_state     = ST_COPY;
                            n_cnt       = i_op.len;
                            n_back      = w_dir_back;
                            n_cw_valid  = 1'b0;
                            n_ptr_src   = w_dir_back ? w_src + w_len1 : w_src;
                            n_ptr_dst   = w_dir_back ? w_va + w_len1 : w_va;
                        end
                        default: begin
                            n_res_kind = RES_ZERO;
                        end
                    endcase
                end
            end

            ST_FILL: begin
                w_ev_wa = r_ptr_dst[VAB-1:1];
                w_od_wa = r_ptr_dst[VAB-1:1];
                w_ev_wd = r_fill;
                w_od_wd = r_fill;
                if (r_cnt != '0) begin
                    w_ev_we   = !r_ptr_dst[0];
                    w_od_we   = r_ptr_dst[0];
                    n_ptr_dst = r_ptr_dst + VAB'(1);
                    n_cnt     = r_cnt - FIELD_BITS'(1);
                end else if (w_res_free) begin
                    n_res_valid = 1'b1;
                    n_res_kind  = RES_ZERO;
                    n_state     = ST_RUN;
                end
            end

            ST_COPY: begin
                w_ev_ra = r_ptr_src[VAB-1:1];
                w_od_ra = r_ptr_src[VAB-1:1];
                w_ev_wa = r_cw_dst[VAB-1:1];
                w_od_wa = r_cw_dst[VAB-1:1];
                w_ev_wd = w_cp_byte;
                w_od_wd = w_cp_byte;
                // write back the byte read in the previous cycle
                if (r_cw_valid) begin
                    w_ev_we    = !r_cw_dst[0];
                    w_od_we    = r_cw_dst[0];
                    n_cw_valid = 1'b0;
                end
                if (r_cnt != '0) begin
                    w_ev_re    = !r_ptr_src[0];
                    w_od_re    = r_ptr_src[0];
                    n_cw_valid = 1'b1;
                    n_cw_bank  = r_ptr_src[0];
                    n_cw_dst   = r_ptr_dst;
                    n_ptr_src  = r_back ? r_ptr_src - VAB'(1) : r_ptr_src + VAB'(1);
                    n_ptr_dst  = r_back ? r_ptr_dst - VAB'(1) : r_ptr_dst + VAB'(1);
                    n_cnt      = r_cnt - FIELD_BITS'(1);
                end else if (!r_cw_valid && w_res_free) begin
                    n_res_valid = 1'b1;
                    n_res_kind  = RES_ZERO;
                    n_state     = ST_RUN;
                end
            end

            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_comb begin
        case (r_res_kind)
            RES_BYTE:   o_res_data = {8'h00, (r_res_bank ? r_od_rd : r_ev_rd)};
            RES_WORD:   o_res_data = {r_ev_rd, r_od_rd};
            RES_COLOR:  o_res_data = FIELD_BITS'(r_c_rd);
            RES_SCROLL: o_res_data = FIELD_BITS'(r_s_rd);
            default:    o_res_data = '0;
        endcase
    end

    a_no_pop_in_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !o_pop)
        else $error("request taken while a transfer runs");

    a_pop_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_op_valid)
        else $error("request taken from an empty queue");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && i_res_full) |=> (r_res_valid && $stable(r_res_kind)))
        else $error("stalled result lost or changed");

    a_copy_write_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cw_valid |-> (r_state == ST_COPY))
        else $error("copy write pending outside a copy");

    a_transfer_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_COPY) && (r_cnt != '0)) |-> !n_res_valid || r_res_valid)
        else $error("result raised before the copy finished");

endmodule

// File: hw/rtl/video_memory_access_with_dma_fill_copy.sv
// ----------------------------------------------------------------------------
// video_memory_access_with_dma_fill_copy: video processor memory subsystem
// Byte video memory with big-endian word access, color and scroll memories,
// and in-memory fill and overlap-safe copy. One result per request.
//
//   channel   direction  handshake          payload
//   request   in         push / full        i_cmd i_addr i_data i_source_addr
//                                           i_length
//   result    out        empty / pop        o_read_data
//
// Single accesses: one request per cycle while the result queue has room;
// each result is formed from the registered read of the memory banks.
// Fills and copies move one byte per cycle on the video bank ports. Reset
// clears the color and scroll valid bits at once; there is no clearing pass.
// A full result queue stalls the back end, which then stops taking requests
// from the four-entry request queue.
// ----------------------------------------------------------------------------
module video_memory_access_with_dma_fill_copy #(
    parameter int VIDEO_ADDR_BITS = 16,
    parameter int COLOR_ENTRIES   = 64,
    parameter int SCROLL_ENTRIES  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [vmac_pkg::CMD_BITS-1:0]   i_cmd,
    input  logic [vmac_pkg::FIELD_BITS-1:0] i_addr,
    input  logic [vmac_pkg::FIELD_BITS-1:0] i_data,
    input  logic [vmac_pkg::FIELD_BITS-1:0] i_source_addr,
    input  logic [vmac_pkg::FIELD_BITS-1:0] i_length,
    output logic                            empty,
    input  logic                            pop,
    output logic [vmac_pkg::FIELD_BITS-1:0] o_read_data
);

    import vmac_pkg::*;

    localparam int OP_BITS   = $bits(t_op);
    localparam int REQ_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    t_op                   w_front_op;
    logic [OP_BITS-1:0]    w_q_data;
    t_op                   w_back_op;
    logic                  w_q_empty;
    logic                  w_q_pop;
    logic                  w_res_full;
    logic                  w_res_push;
    logic [FIELD_BITS-1:0] w_res_data;

    assign w_back_op = w_q_data;

    vmac_front #(
        .COLOR_ENTRIES  (COLOR_ENTRIES),
        .SCROLL_ENTRIES (SCROLL_ENTRIES)
    ) u_front (
        .i_cmd         (i_cmd),
        .i_addr        (i_addr),
        .i_data        (i_data),
        .i_source_addr (i_source_addr),
        .i_length      (i_length),
        .o_op          (w_front_op)
    );

    vmac_queue #(
        .WIDTH (OP_BITS),
        .DEPTH (REQ_DEPTH)
    ) u_req_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_front_op),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    vmac_back #(
        .VIDEO_ADDR_BITS (VIDEO_ADDR_BITS),
        .COLOR_ENTRIES   (COLOR_ENTRIES),
        .SCROLL_ENTRIES  (SCROLL_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!w_q_empty),
        .i_op       (w_back_op),
        .o_pop      (w_q_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res_data (w_res_data)
    );

    vmac_queue #(
        .WIDTH (FIELD_BITS),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_read_data),
        .o_empty (empty)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: bench for the video memory access block with fill and copy
// Requests go in through the push/full queue port and results come back
// through empty/pop. A behavioural memory image predicts every read value.
// Each result is checked in order against that prediction. Directed tests
// cover the edges and random traffic follows, with random stalls on both
// sides and one long hold-off of the result side.
// ----------------------------------------------------------------------------
module tb_top;
    import vmac_pkg::*;

    localparam int VIDEO_ADDR_BITS = 16;
    localparam int COLOR_ENTRIES   = 64;
    localparam int SCROLL_ENTRIES  = 64;
    localparam int VIDEO_BYTES     = 1 << VIDEO_ADDR_BITS;

    localparam logic [CMD_BITS-1:0] CMD_FIRST_UNUSED = CMD_COPY + 1'b1;
    localparam logic [CMD_BITS-1:0] CMD_LAST_CODE    = '1;

    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 40;
    // a full-length copy moves no result until all of its bytes are done
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int HOLD_OFF       = 300;
    localparam int MAX_PRINTED    = 20;

    typedef struct {
        logic [CMD_BITS-1:0]   cmd;
        logic [FIELD_BITS-1:0] addr;
        logic [FIELD_BITS-1:0] data;
        logic [FIELD_BITS-1:0] source_addr;
        logic [FIELD_BITS-1:0] length;
    } vram_request_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [CMD_BITS-1:0]   i_cmd;
    logic [FIELD_BITS-1:0] i_addr;
    logic [FIELD_BITS-1:0] i_data;
    logic [FIELD_BITS-1:0] i_source_addr;
    logic [FIELD_BITS-1:0] i_length;
    logic                  empty;
    logic                  pop;
    logic [FIELD_BITS-1:0] o_read_data;

    // memory image of the block
    logic [7:0]  vram_image   [VIDEO_BYTES];
    logic [11:0] color_image  [COLOR_ENTRIES];
    logic [9:0]  scroll_image [SCROLL_ENTRIES];

    logic [FIELD_BITS-1:0] expected_read_data [$];
    logic [FIELD_BITS-1:0] recent_addr [$];

    int sender_idle_pct      = 0;
    int receiver_idle_pct    = 0;
    int receiver_hold_cycles = 0;
    int mismatch_count       = 0;
    int results_checked      = 0;
    int singles_sent         = 0;
    int fills_sent           = 0;
    int copies_sent          = 0;
    int unused_sent          = 0;
    longint bytes_moved      = 0;

    video_memory_access_with_dma_fill_copy #(
        .VIDEO_ADDR_BITS(VIDEO_ADDR_BITS),
        .COLOR_ENTRIES  (COLOR_ENTRIES),
        .SCROLL_ENTRIES (SCROLL_ENTRIES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_addr       (i_addr),
        .i_data       (i_data),
        .i_source_addr(i_source_addr),
        .i_length     (i_length),
        .empty        (empty),
        .pop          (pop),
        .o_read_data  (o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the memory image and return the value it reads.
    function automatic logic [FIELD_BITS-1:0] predict_read_data(input vram_request_t r);
        logic [FIELD_BITS-1:0] word_addr;
        logic [FIELD_BITS-1:0] dst;
        logic [FIELD_BITS-1:0] src;
        logic [FIELD_BITS-1:0] value;
        int k;
        word_addr = {r.addr[FIELD_BITS-1:1], 1'b0};
        value = '0;
        case (r.cmd)
            CMD_RD_BYTE: value = {8'h00, vram_image[r.addr]};
            CMD_RD_WORD: begin
                dst = word_addr + 16'd1;
                value = {vram_image[word_addr], vram_image[dst]};
            end
            CMD_WR_BYTE: vram_image[r.addr] = r.data[7:0];
            CMD_WR_WORD: begin
                dst = word_addr + 16'd1;
                vram_image[word_addr] = r.data[15:8];
                vram_image[dst] = r.data[7:0];
            end
            CMD_RD_COLOR:  value = FIELD_BITS'(color_image[r.addr % COLOR_ENTRIES]);
            CMD_WR_COLOR:  color_image[r.addr % COLOR_ENTRIES] = r.data[11:0];
            CMD_RD_SCROLL: value = FIELD_BITS'(scroll_image[r.addr % SCROLL_ENTRIES]);
            CMD_WR_SCROLL: scroll_image[r.addr % SCROLL_ENTRIES] = r.data[9:0];
            CMD_FILL: begin
                for (k = 0; k < r.length; k++) begin
                    dst = r.addr + 16'(k);
                    vram_image[dst] = r.data[7:0];
                end
            end
            CMD_COPY: begin
                // run backward when the destination lies above the source
                if (r.addr > r.source_addr) begin
                    for (k = int'(r.length) - 1; k >= 0; k--) begin
                        dst = r.addr + 16'(k);
                        src = r.source_addr + 16'(k);
                        vram_image[dst] = vram_image[src];
                    end
                end else begin
                    for (k = 0; k < r.length; k++) begin
                        dst = r.addr + 16'(k);
                        src = r.source_addr + 16'(k);
                        vram_image[dst] = vram_image[src];
                    end
                end
            end
            default: value = '0;
        endcase
        return value;
    endfunction

    function automatic vram_request_t make_request(
        input logic [CMD_BITS-1:0]   cmd,
        input logic [FIELD_BITS-1:0] addr,
        input logic [FIELD_BITS-1:0] data,
        input logic [FIELD_BITS-1:0] source_addr,
        input logic [FIELD_BITS-1:0] length
    );
        vram_request_t r;
        r.cmd = cmd;
        r.addr = addr;
        r.data = data;
        r.source_addr = source_addr;
        r.length = length;
        return r;
    endfunction

    function automatic vram_request_t random_request();
        vram_request_t r;
        int roll;
        r.data = 16'($urandom);
        r.source_addr = 16'($urandom);
        r.length = 16'($urandom);
        // aim two in five accesses at recently written bytes so reads hit fresh data
        roll = $urandom_range(99);
        if (roll < 40 && recent_addr.size() != 0)
            r.addr = recent_addr[$urandom_range(recent_addr.size() - 1)]
                     + 16'($urandom_range(3));
        else if (roll < 60)
            r.addr = 16'hFFC0 + 16'($urandom_range(63));
        else
            r.addr = 16'($urandom);
        roll = $urandom_range(99);
        if (roll < 12)      r.cmd = CMD_RD_BYTE;
        else if (roll < 22) r.cmd = CMD_RD_WORD;
        else if (roll < 32) r.cmd = CMD_WR_BYTE;
        else if (roll < 42) r.cmd = CMD_WR_WORD;
        else if (roll < 49) r.cmd = CMD_RD_COLOR;
        else if (roll < 56) r.cmd = CMD_WR_COLOR;
        else if (roll < 63) r.cmd = CMD_RD_SCROLL;
        else if (roll < 70) r.cmd = CMD_WR_SCROLL;
        else if (roll < 82) r.cmd = CMD_FILL;
        else if (roll < 94) r.cmd = CMD_COPY;
        else                r.cmd = CMD_FIRST_UNUSED
                                    + CMD_BITS'($urandom_range(CMD_LAST_CODE - CMD_FIRST_UNUSED));
        if (r.cmd == CMD_FILL || r.cmd == CMD_COPY) begin
            // keep transfers short, with the odd long one
            roll = $urandom_range(99);
            if (roll < 7)       r.length = '0;
            else if (roll < 75) r.length = 16'($urandom_range(32, 1));
            else if (roll < 97) r.length = 16'($urandom_range(512, 33));
            else                r.length = 16'($urandom_range(4096, 513));
            // place the source within 32 bytes of the destination half of the time
            if (r.cmd == CMD_COPY && $urandom_range(1))
                r.source_addr = r.addr + 16'($urandom_range(64)) - 16'd32;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns  mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_read_data(input logic [FIELD_BITS-1:0] got);
        logic [FIELD_BITS-1:0] want;
        results_checked++;
        if (expected_read_data.size() == 0) begin
            report_mismatch($sformatf("read_data %04h with no request outstanding", got));
        end else begin
            want = expected_read_data.pop_front();
            if (got !== want)
                report_mismatch($sformatf("read_data %04h, expected %04h", got, want));
        end
    endtask

    // Offer one request and hold it until taken. Push stays high on return;
    // the next call or the end of stimulus drops it in the same time step.
    task automatic send_request(input vram_request_t r);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_cmd         <= r.cmd;
        i_addr        <= r.addr;
        i_data        <= r.data;
        i_source_addr <= r.source_addr;
        i_length      <= r.length;
        do @(posedge i_clk); while (full);
        expected_read_data.push_back(predict_read_data(r));
        case (r.cmd)
            CMD_FILL: begin
                fills_sent++;
                bytes_moved += r.length;
            end
            CMD_COPY: begin
                copies_sent++;
                bytes_moved += r.length;
            end
            CMD_RD_BYTE, CMD_RD_WORD, CMD_WR_BYTE, CMD_WR_WORD,
            CMD_RD_COLOR, CMD_WR_COLOR, CMD_RD_SCROLL, CMD_WR_SCROLL:
                singles_sent++;
            default: unused_sent++;
        endcase
        if (r.cmd == CMD_WR_BYTE || r.cmd == CMD_WR_WORD || r.cmd == CMD_FILL
            || r.cmd == CMD_COPY) begin
            recent_addr.push_back(r.addr);
            if (recent_addr.size() > 16)
                void'(recent_addr.pop_front());
        end
    endtask

    task automatic test_reset_state();
        send_request(make_request(CMD_RD_COLOR, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_SCROLL, 16'h0040, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    endtask

    // Write every video byte first so that no later read meets an unwritten one.
    task automatic test_fill_and_bytes();
        send_request(make_request(CMD_FILL, 16'h0000, 16'hFFA5, 16'h0000, 16'hFFFF));
        send_request(make_request(CMD_WR_BYTE, 16'hFFFF, 16'hFF3C, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_BYTE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_request(CMD_FILL, 16'h1000, 16'h00FF, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_BYTE, 16'h1000, 16'h0000, 16'h0000, 16'h0000));
        // wrap past the top of video memory
        send_request(make_request(CMD_FILL, 16'hFFF0, 16'h0077, 16'h0000, 16'h0020));
        send_request(make_request(CMD_RD_WORD, 16'h000E, 16'h0000, 16'h0000, 16'h0000));
    endtask

    task automatic test_word_access();
        send_request(make_request(CMD_WR_WORD, 16'h0101, 16'hBEEF, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_BYTE, 16'h0100, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_WORD, 16'h0101, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_request(CMD_WR_WORD, 16'hFFFF, 16'h1234, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_WORD, 16'hFFFE, 16'h0000, 16'h0000, 16'h0000));
    endtask

    task automatic test_color_scroll_widths();
        send_request(make_request(CMD_WR_COLOR, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_COLOR, 16'h003F, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_request(CMD_WR_SCROLL, 16'h0041, 16'hFFFF, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_SCROLL, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
    endtask

    task automatic test_copy_directions();
        send_request(make_request(CMD_WR_WORD, 16'h2000, 16'h0102, 16'h0000, 16'h0000));
        send_request(make_request(CMD_WR_WORD, 16'h2002, 16'h0304, 16'h0000, 16'h0000));
        // overlapping, destination above source: must run backward
        send_request(make_request(CMD_COPY, 16'h2001, 16'h0000, 16'h2000, 16'h0004));
        send_request(make_request(CMD_RD_WORD, 16'h2002, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_request(CMD_COPY, 16'h2000, 16'h0000, 16'h2001, 16'h0004));
        send_request(make_request(CMD_COPY, 16'h2000, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_request(CMD_RD_WORD, 16'h2000, 16'h0000, 16'h0000, 16'h0000));
        // longer than a signed 16-bit count, backward, destination wraps
        send_request(make_request(CMD_COPY, 16'h8000, 16'h0000, 16'h0000, 16'd40000));
        send_request(make_request(CMD_RD_WORD, 16'h1C3E, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_request(CMD_COPY, 16'h4000, 16'h0000, 16'hC000, 16'hFFFF));
        send_request(make_request(CMD_RD_WORD, 16'h4000, 16'h0000, 16'h0000, 16'h0000));
    endtask

    task automatic test_unused_commands();
        send_request(make_request(CMD_FIRST_UNUSED, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(make_request(CMD_LAST_CODE, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0010));
    endtask

    task automatic test_random_traffic(input int n_requests, input int idle_pct);
        int i;
        sender_idle_pct = idle_pct;
        receiver_idle_pct = idle_pct;
        for (i = 0; i < n_requests; i++)
            send_request(random_request());
    endtask

    // Hold the result side off while requests keep coming, so both queues fill.
    task automatic test_backpressure(input int n_requests);
        vram_request_t r;
        int i;
        sender_idle_pct = 0;
        receiver_hold_cycles = HOLD_OFF;
        for (i = 0; i < n_requests; i++) begin
            r = random_request();
            if (r.cmd == CMD_FILL || r.cmd == CMD_COPY)
                r.length = 16'($urandom_range(4));
            send_request(r);
        end
    endtask

    initial begin : result_sink
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                check_read_data(o_read_data);
            if (receiver_hold_cycles > 0) begin
                receiver_hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        foreach (color_image[i]) color_image[i] = '0;
        foreach (scroll_image[i]) scroll_image[i] = '0;
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_cmd         <= '0;
        i_addr        <= '0;
        i_data        <= '0;
        i_source_addr <= '0;
        i_length      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_fill_and_bytes();
        test_word_access();
        test_color_scroll_widths();
        test_copy_directions();
        test_unused_commands();
        test_random_traffic(600, 23);
        test_random_traffic(300, 0);
        test_backpressure(80);
        test_random_traffic(470, 23);

        push <= 1'b0;
        receiver_idle_pct = 0;
        while (expected_read_data.size() != 0)
            @(posedge i_clk);
        // catch any result that turns up unasked
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d single accesses, %0d fills, %0d copies (%0d bytes moved)",
                 singles_sent, fills_sent, copies_sent, bytes_moved);
        $display("and %0d unused codes; %0d results checked, %0d mismatches",
                 unused_sent, results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
